>>> src/swept_fist_cylinder_overlap_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for swept_fist_cylinder_overlap
// Clocked property checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SWEPT_FIST_CYLINDER_OVERLAP_ASSERT_SVH
`define SWEPT_FIST_CYLINDER_OVERLAP_ASSERT_SVH

`ifndef ASSERT_OFF
// check on every edge outside reset
`define SWFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check on every edge, reset included
`define SWFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SWFC_ASSERT(label, prop, msg)
`define SWFC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> src/swfc_pkg.sv
// ----------------------------------------------------------------------------
// swfc_pkg
// Types and constants for the swept fist / cylinder overlap test.
// ----------------------------------------------------------------------------
package swfc_pkg;

    localparam int unsigned SAMPLES_DEF = 4;

    localparam int unsigned FR_W  = 6;
    localparam int unsigned FL_W  = 9;
    localparam int unsigned PAW   = 3;
    localparam int unsigned PDW   = 32;

    localparam logic [FR_W-1:0] FR_RESET = 6'd12;
    localparam logic [FL_W-1:0] FL_RESET = 9'd24;

    typedef enum logic [0:0] {
        REG_FIST_RADIUS = 1'b0,
        REG_FIST_LENGTH = 1'b1
    } t_reg_idx;

endpackage

>>> src/swept_fist_cylinder_overlap.sv
// An accepted input transaction reaches o_valid through stages 1 to 4.
// Throughput: one transaction per cycle while o_stall is low;
// four register stages, each with its own valid bit, advance independently
// so bubbles are squeezed out. The last stage is the output register;
// o_stall rises only when all four stages hold data and i_stall is high.
// Reset clears all valid bits and loads fist radius 12 and length 24.
// ----------------------------------------------------------------------------
// swept_fist_cylinder_overlap
// Samples a fist sweep at SAMPLES+1 points (exact 1/SAMPLES fixed point)
// and flags overlap of any sample with an upright cylinder.
// ----------------------------------------------------------------------------
`include "swept_fist_cylinder_overlap_assert.svh"

module swept_fist_cylinder_overlap #(
    parameter int unsigned SAMPLES = swfc_pkg::SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swfc_pkg::PAW-1:0]    paddr,
    input  logic [swfc_pkg::PDW-1:0]    pwdata,
    output logic [swfc_pkg::PDW-1:0]    prdata,
    output logic                        pready,

    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [15:0]          i_start_x,
    input  logic signed [15:0]          i_start_y,
    input  logic signed [15:0]          i_start_z,
    input  logic signed [15:0]          i_end_x,
    input  logic signed [15:0]          i_end_y,
    input  logic signed [15:0]          i_end_z,
    input  logic signed [15:0]          i_target_x,
    input  logic signed [15:0]          i_target_y,
    input  logic signed [15:0]          i_target_z,
    input  logic        [11:0]          i_target_radius,
    input  logic        [11:0]          i_target_height,
    input  logic signed [12:0]          i_target_drop,

    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit
);
    import swfc_pkg::*;

    localparam int unsigned NL  = SAMPLES + 1;
    localparam int unsigned KB  = $clog2(SAMPLES + 1);
    localparam int unsigned DW  = 17 + KB;      // horizontal offset, signed
    localparam int unsigned MW  = DW - 1;       // horizontal magnitude
    localparam int unsigned VW  = 20 + KB;      // vertical positions, signed
    localparam int unsigned CW  = 13 + KB;      // scaled reach
    localparam int unsigned SQW = 2 * MW + 1;

    localparam logic signed [VW-1:0] NSV = VW'(SAMPLES);
    localparam logic        [CW-1:0] NSC = CW'(SAMPLES);

    // ---------------- configuration ----------------
    logic [FR_W-1:0] r_fist_radius;
    logic [FL_W-1:0] r_fist_length;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fist_radius <= FR_RESET;
            r_fist_length <= FL_RESET;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_FIST_RADIUS: r_fist_radius <= pwdata[FR_W-1:0];
                REG_FIST_LENGTH: r_fist_length <= pwdata[FL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_FIST_RADIUS: prdata = {{(PDW-FR_W){1'b0}}, r_fist_radius};
            REG_FIST_LENGTH: prdata = {{(PDW-FL_W){1'b0}}, r_fist_length};
        endcase
    end

    // ---------------- pipeline control ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: offsets relative to the cylinder ----------------
    logic signed [16:0] r_ax, r_bx, r_az, r_bz;
    logic signed [15:0] r_sy, r_ey;
    logic signed [16:0] r_bot1;
    logic signed [17:0] r_top1;
    logic        [12:0] r_crad1;
    logic signed [6:0]  r_fr1;
    logic signed [9:0]  r_fd1;
    logic               r_empty1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ax     <= 17'(i_start_x) - 17'(i_target_x);
            r_bx     <= 17'(i_end_x) - 17'(i_target_x);
            r_az     <= 17'(i_start_z) - 17'(i_target_z);
            r_bz     <= 17'(i_end_z) - 17'(i_target_z);
            r_sy     <= i_start_y;
            r_ey     <= i_end_y;
            r_bot1   <= 17'(i_target_y) - 17'(i_target_drop);
            r_top1   <= 18'(i_target_y) - 18'(i_target_drop)
                        + $signed({6'b0, i_target_height});
            r_crad1  <= 13'(i_target_radius) + 13'(r_fist_radius);
            r_fr1    <= $signed({1'b0, r_fist_radius});
            r_fd1    <= $signed({4'b0, r_fist_radius}) - $signed({1'b0, r_fist_length});
            r_empty1 <= (i_target_radius == '0) || (i_target_height == '0);
        end
    end

    // ---------------- stage 2..4: shared terms ----------------
    logic signed [VW-1:0]   r_frn, r_fbn, r_botn, r_topn;
    logic        [CW-1:0]   r_cradn;
    logic                   r_empty2;
    logic        [2*CW-1:0] r_crad2;
    logic                   r_empty3;
    logic                   r_hit;
    logic        [NL-1:0]   lane_hit;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_frn    <= VW'(r_fr1) * NSV;
            r_fbn    <= VW'(r_fd1) * NSV;
            r_botn   <= VW'(r_bot1) * NSV;
            r_topn   <= VW'(r_top1) * NSV;
            r_cradn  <= CW'(r_crad1) * NSC;
            r_empty2 <= r_empty1;
        end
        if (en3) begin
            r_crad2  <= (2*CW)'(r_cradn) * (2*CW)'(r_cradn);
            r_empty3 <= r_empty2;
        end
        if (en4) begin
            r_hit    <= !r_empty3 && (|lane_hit);
        end
    end

    // ---------------- sample lanes ----------------
    for (genvar k = 0; k < NL; k++) begin : g_lane
        localparam logic signed [DW-1:0] CA  = DW'(SAMPLES - k);
        localparam logic signed [DW-1:0] CB  = DW'(k);
        localparam logic signed [VW-1:0] CAV = VW'(SAMPLES - k);
        localparam logic signed [VW-1:0] CBV = VW'(k);

        logic signed [DW-1:0]   dx, dz;
        logic signed [VW-1:0]   py;
        logic        [MW-1:0]   r_mx, r_mz;
        logic signed [VW-1:0]   r_py;
        logic        [2*MW-1:0] r_sqx, r_sqz;
        logic                   r_vok;

        assign dx = DW'(r_ax) * CA + DW'(r_bx) * CB;
        assign dz = DW'(r_az) * CA + DW'(r_bz) * CB;
        assign py = VW'(r_sy) * CAV + VW'(r_ey) * CBV;

        always_ff @(posedge i_clk) begin
            if (en2) begin
                r_mx <= dx[DW-1] ? MW'(-dx) : MW'(dx);
                r_mz <= dz[DW-1] ? MW'(-dz) : MW'(dz);
                r_py <= py;
            end
            if (en3) begin
                r_sqx <= (2*MW)'(r_mx) * (2*MW)'(r_mx);
                r_sqz <= (2*MW)'(r_mz) * (2*MW)'(r_mz);
                r_vok <= (r_py + r_frn >= r_botn) && (r_py + r_fbn <= r_topn);
            end
        end

        assign lane_hit[k] = r_vok
                             && (SQW'(r_sqx) + SQW'(r_sqz) <= SQW'(r_crad2));
    end

    assign o_hit = r_hit;

    // ---------------- checks ----------------
    `SWFC_ASSERT(a_empty_no_hit, (r_v3 && r_empty3 && en4) |=> (r_v4 && !r_hit), "empty hit")
    `SWFC_ASSERT(a_stall_full, o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_stall), "bad stall")
    `SWFC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> !o_valid, "valid after reset")
    `SWFC_ASSERT(a_reset_regs, $past(!i_rst_n) |-> (r_fist_radius == FR_RESET && r_fist_length == FL_RESET), "bad reset regs")

endmodule

>>> sim/swept_fist_cylinder_overlap_tb.sv
// ----------------------------------------------------------------------------
// swept_fist_cylinder_overlap_tb
// Drives fist sweeps and cylinders through the valid/stall input channel
// and checks every hit flag against its table value or an exact fixed-point
// prediction. A directed table covers edges and extremes; near-target random
// sweeps follow, under several fist settings and stall patterns on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module swept_fist_cylinder_overlap_tb;
    import swfc_pkg::*;

    localparam realtime HALF_PERIOD  = 4.0;
    localparam int RESET_CYCLES      = 6;
    localparam int N_SAMP            = SAMPLES_DEF;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int TAIL_CYCLES       = 12;
    localparam int PHASES            = 6;
    localparam int PHASE_ITEMS       = 130;
    localparam int EXP_MODEL         = -1;
    localparam int RAND_SETTING      = -1;

    localparam int PHASE_FR [PHASES] = '{63, 0, RAND_SETTING, 1, 63, RAND_SETTING};
    localparam int PHASE_FL [PHASES] = '{511, 0, RAND_SETTING, 511, 0, RAND_SETTING};

    // sx sy sz, ex ey ez, tx ty tz, radius height drop, expected hit
    localparam int DIR_ROWS = 20;
    localparam int DIR_TAB [DIR_ROWS][13] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 100, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 100, 0, 0, 0},
        '{-32768, -32768, -32768, 32767, 32767, 32767,
          -32768, -32768, -32768, 0, 4095, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1},
        '{-32768, -32768, -32768, 32767, 32767, 32767,
          -32768, -32768, -32768, 4095, 4095, 0, 1},
        '{32767, 32767, 32767, 32767, 32767, 32767,
          -32768, -32768, -32768, 1, 1, 0, 0},
        '{32767, 32767, 32767, -32768, -32768, -32768,
          0, 0, 0, 4095, 4095, 4095, EXP_MODEL},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 10, 1, -4096, 0},
        '{0, 4096, 0, 0, 4096, 0, 0, 0, 0, 10, 1, -4096, EXP_MODEL},
        '{-100, 0, 0, 100, 0, 0, 0, 0, 0, 1, 1, 0, EXP_MODEL},
        '{-1000, 0, 0, 1000, 0, 0, 250, 0, 0, 1, 1, 0, EXP_MODEL},
        '{20, 0, 0, 20, 0, 0, 0, 0, 0, 8, 1, 0, EXP_MODEL},
        '{21, 0, 0, 21, 0, 0, 0, 0, 0, 8, 1, 0, EXP_MODEL},
        '{12, 0, 16, 12, 0, 16, 0, 0, 0, 8, 1, 0, EXP_MODEL},
        '{0, 22, 0, 0, 22, 0, 0, 0, 0, 8, 10, 0, EXP_MODEL},
        '{0, 23, 0, 0, 23, 0, 0, 0, 0, 8, 10, 0, EXP_MODEL},
        '{0, -12, 0, 0, -12, 0, 0, 0, 0, 8, 10, 0, EXP_MODEL},
        '{0, -13, 0, 0, -13, 0, 0, 0, 0, 8, 10, 0, EXP_MODEL},
        '{-5, 7, -9, 5, -7, 9, 0, 0, 0, 4095, 4095, -1, EXP_MODEL},
        '{32767, 32767, 32767, 32767, 32767, 32767,
          32767, 32767, 32767, 4095, 4095, -4096, EXP_MODEL}
    };

    typedef struct packed {
        logic signed [15:0] sx, sy, sz;
        logic signed [15:0] ex, ey, ez;
        logic signed [15:0] tx, ty, tz;
        logic        [11:0] trad, thgt;
        logic signed [12:0] tdrop;
    } t_sweep;

    typedef struct packed {
        logic        hit;
        logic [31:0] seq;
    } t_due_hit;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PAW-1:0]            paddr = '0;
    logic [PDW-1:0]            pwdata = '0;
    logic [PDW-1:0]            prdata;
    logic                      pready;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [15:0]        i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [15:0]        i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic signed [15:0]        i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic        [11:0]        i_target_radius = '0, i_target_height = '0;
    logic signed [12:0]        i_target_drop = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic                      o_hit;

    logic [FR_W-1:0]           fist_rad_q = FR_RESET;
    logic [FL_W-1:0]           fist_len_q = FL_RESET;
    t_due_hit                  pending_hits [$];
    t_due_hit                  head_hit;
    int                        snd_idle_pct = 0;
    int                        rcv_idle_pct = 0;
    int                        err_cnt = 0;
    int                        items_sent = 0;
    int                        results_seen = 0;
    int                        hits_seen = 0;
    int                        settings_cnt = 1;
    int                        quiet_cycles = 0;

    swept_fist_cylinder_overlap u_top (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic predict_overlap(input t_sweep it);
        longint n, crad2, bottom, top, px, py, pz, dx, dz, ftop;
        logic   hit;
        n   = N_SAMP;
        hit = 1'b0;
        if (it.trad != 0 && it.thgt != 0) begin
            crad2  = (longint'(it.trad) + longint'(fist_rad_q)) * n;
            crad2  = crad2 * crad2;
            bottom = (longint'($signed(it.ty)) - longint'($signed(it.tdrop))) * n;
            top    = bottom + longint'(it.thgt) * n;
            for (int k = 0; k <= N_SAMP; k++) begin
                px = longint'($signed(it.sx)) * n
                   + (longint'($signed(it.ex)) - longint'($signed(it.sx))) * k;
                py = longint'($signed(it.sy)) * n
                   + (longint'($signed(it.ey)) - longint'($signed(it.sy))) * k;
                pz = longint'($signed(it.sz)) * n
                   + (longint'($signed(it.ez)) - longint'($signed(it.sz))) * k;
                dx = px - longint'($signed(it.tx)) * n;
                dz = pz - longint'($signed(it.tz)) * n;
                ftop = py + longint'(fist_rad_q) * n;
                if (dx * dx + dz * dz <= crad2 && ftop >= bottom
                    && ftop - longint'(fist_len_q) * n <= top)
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_sweep row_item(input int f [13]);
        t_sweep it;
        it.sx    = 16'(f[0]);
        it.sy    = 16'(f[1]);
        it.sz    = 16'(f[2]);
        it.ex    = 16'(f[3]);
        it.ey    = 16'(f[4]);
        it.ez    = 16'(f[5]);
        it.tx    = 16'(f[6]);
        it.ty    = 16'(f[7]);
        it.tz    = 16'(f[8]);
        it.trad  = 12'(f[9]);
        it.thgt  = 12'(f[10]);
        it.tdrop = 13'(f[11]);
        return it;
    endfunction

    function automatic int spread(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    // mostly sweeps placed around the cylinder, some raw noise, some empty ones
    function automatic t_sweep gen_sweep();
        int f [13];
        int pick, reach, ydepth, bottom;
        pick = $urandom_range(0, 15);
        f[12] = 0;
        if (pick == 0) begin
            for (int i = 0; i < 12; i++)
                f[i] = int'($urandom());
        end else begin
            f[6]  = int'($urandom_range(0, 65535)) - 32768;
            f[7]  = int'($urandom_range(0, 65535)) - 32768;
            f[8]  = int'($urandom_range(0, 65535)) - 32768;
            f[9]  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 4095))
                                                : int'($urandom_range(1, 60));
            f[10] = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 4095))
                                                : int'($urandom_range(1, 200));
            f[11] = int'($urandom_range(0, 8191)) - 4096;
            bottom = f[7] - f[11];
            reach  = f[9] + int'(fist_rad_q) + 8;
            ydepth = f[10] + int'(fist_len_q) + 16;
            f[0] = f[6] + spread(reach + reach / 2);
            f[2] = f[8] + spread(reach + reach / 2);
            f[1] = bottom - int'(fist_rad_q) - 8 + int'($urandom_range(0, ydepth));
            if ($urandom_range(0, 3) == 0) begin
                f[3] = f[0];
                f[4] = f[1];
                f[5] = f[2];
            end else begin
                f[3] = f[0] + spread(2 * reach);
                f[4] = f[1] + spread(ydepth);
                f[5] = f[2] + spread(2 * reach);
            end
            if (pick == 1)
                f[9] = 0;
            else if (pick == 2)
                f[10] = 0;
        end
        return row_item(f);
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic send_item(input t_sweep it, input int want);
        t_due_hit d;
        @(negedge i_clk);
        while (int'($urandom_range(0, 99)) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_start_x       <= it.sx;
        i_start_y       <= it.sy;
        i_start_z       <= it.sz;
        i_end_x         <= it.ex;
        i_end_y         <= it.ey;
        i_end_z         <= it.ez;
        i_target_x      <= it.tx;
        i_target_y      <= it.ty;
        i_target_z      <= it.tz;
        i_target_radius <= it.trad;
        i_target_height <= it.thgt;
        i_target_drop   <= it.tdrop;
        i_valid         <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        d.hit = (want == EXP_MODEL) ? predict_overlap(it) : want[0];
        d.seq = items_sent;
        pending_hits.push_back(d);
        items_sent++;
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_hits.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input t_reg_idx r, input logic [PDW-1:0] wdata,
                            output logic [PDW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PAW'({r, 2'b00});
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_check(input t_reg_idx r);
        logic [PDW-1:0] got, want;
        apb_xfer(1'b0, r, '0, got);
        want = (r == REG_FIST_RADIUS) ? PDW'(fist_rad_q) : PDW'(fist_len_q);
        if (got !== want)
            note_mismatch($sformatf("register %s readback", r.name()), 64'(want), 64'(got));
    endtask

    // upper data bits carry junk; only the register's own width should land
    task automatic cfg_write(input int fr, input int fl);
        logic [PDW-1:0] unused;
        apb_xfer(1'b1, REG_FIST_RADIUS, {26'($urandom()), 6'(fr)}, unused);
        fist_rad_q = 6'(fr);
        read_check(REG_FIST_RADIUS);
        apb_xfer(1'b1, REG_FIST_LENGTH, {23'($urandom()), 9'(fl)}, unused);
        fist_len_q = 9'(fl);
        read_check(REG_FIST_LENGTH);
        settings_cnt++;
    endtask

    always @(negedge i_clk)
        i_stall <= (int'($urandom_range(0, 99)) < rcv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            results_seen++;
            if (pending_hits.size() == 0) begin
                note_mismatch("result transaction with nothing pending", '0, 64'(o_hit));
            end else begin
                head_hit = pending_hits.pop_front();
                if (o_hit !== head_hit.hit)
                    note_mismatch($sformatf("hit, transaction %0d", head_hit.seq),
                                  64'(head_hit.hit), 64'(o_hit));
                if (o_hit === 1'b1)
                    hits_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     quiet_cycles, pending_hits.size());
            $display("swept_fist_cylinder_overlap_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int fr_set, fl_set;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        read_check(REG_FIST_RADIUS);
        read_check(REG_FIST_LENGTH);

        snd_idle_pct = 38;
        rcv_idle_pct = 78;
        // second pass: widest fist with zero length, all rows predicted
        for (int pass = 0; pass < 2; pass++) begin
            for (int r = 0; r < DIR_ROWS; r++)
                send_item(row_item(DIR_TAB[r]), (pass == 0) ? DIR_TAB[r][12] : EXP_MODEL);
            end_burst();
            drain();
            if (pass == 0)
                cfg_write(63, 0);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            snd_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 78 : 0;
            rcv_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 38 : 0;
            fr_set = (PHASE_FR[ph] == RAND_SETTING) ? int'($urandom_range(0, 63))
                                                    : PHASE_FR[ph];
            fl_set = (PHASE_FL[ph] == RAND_SETTING) ? int'($urandom_range(0, 511))
                                                    : PHASE_FL[ph];
            cfg_write(fr_set, fl_set);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    end_burst();
                    drain();
                end
                send_item(gen_sweep(), EXP_MODEL);
            end
            end_burst();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d sweeps sent, %0d results checked (%0d hits) over %0d fist settings",
                 items_sent, results_seen, hits_seen, settings_cnt);
        $display("edge rows, extremes and near-target sweeps under three stall patterns");
        if (err_cnt == 0 && pending_hits.size() == 0) begin
            $display("swept_fist_cylinder_overlap_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d results still pending", err_cnt,
                     pending_hits.size());
            $display("swept_fist_cylinder_overlap_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> swept_fist_cylinder_overlap.f
+incdir+src
src/swfc_pkg.sv
src/swept_fist_cylinder_overlap.sv
sim/swept_fist_cylinder_overlap_tb.sv
